[rtl/apu_fs_pkg.sv]
// ----------------------------------------------------------------------------
// apu_fs_pkg
// Shared types, register addresses and the length table of the frame
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package apu_fs_pkg;

  // channel count and register widths
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned FrameLenW    = 14;
  localparam int unsigned CountW       = 15;
  localparam int unsigned ChanW        = $clog2(NUM_CHANNELS);
  localparam logic [FrameLenW-1:0] FrameLenReset = 14'd7458;

  // register addresses
  localparam logic [15:0] AddrChanBase = 16'h4000;
  localparam logic [15:0] AddrEnable   = 16'h4015;
  localparam logic [15:0] AddrMode     = 16'h4017;
  localparam logic [1:0]  RegLenLoad   = 2'd3;

  // request kinds
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_e;

  // input word
  typedef struct packed {
    logic        req_type;
    logic [15:0] addr;
    logic [7:0]  data;
  } req_word_t;

  // result word
  typedef struct packed {
    logic                    quarter_frame;
    logic                    half_frame;
    logic                    load_valid;
    logic [ChanW-1:0]        load_channel;
    logic [7:0]              load_value;
    logic [NUM_CHANNELS-1:0] clear_mask;
  } res_word_t;

  // length counter load table
  localparam logic [7:0] LenLut [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

endpackage

`default_nettype wire

[rtl/apu_fs_core.sv]
// ----------------------------------------------------------------------------
// apu_fs_core
// Sequencer state, step timing and register decode; gives the result of the
// word in the input register and updates the state when that word moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_fs_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [apu_fs_pkg::FrameLenW-1:0]     cfg_wdata_i,
  input  wire logic                                 advance_i,
  input  wire apu_fs_pkg::req_word_t                req_i,
  output apu_fs_pkg::res_word_t                     res_o
);
  import apu_fs_pkg::*;

  logic [FrameLenW-1:0]    frame_len_q;
  logic [1:0]              step_q, step_d;
  logic [CountW-1:0]       count_q, count_d;
  logic                    long_mode_q, long_mode_d;
  logic [NUM_CHANNELS-1:0] enables_q, enables_d;

  logic [CountW-1:0]       fl_ext;
  logic [CountW-1:0]       step_len;
  logic [CountW-1:0]       count_tmp;
  logic [ChanW-1:0]        chan;
  res_word_t               res;

  // frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FrameLenReset;
    end else if (cfg_we_i) begin
      frame_len_q <= cfg_wdata_i;
    end
  end

  assign fl_ext = {1'b0, frame_len_q};

  // reload length of the current step, clamped at zero
  always_comb begin
    step_len = fl_ext;
    if (step_q == 2'd1) begin
      step_len = (frame_len_q < 14'd2) ? '0 : fl_ext - 15'd2;
    end else if (step_q == 2'd3 && long_mode_q) begin
      step_len = (frame_len_q < 14'd3) ? '0 : {frame_len_q, 1'b0} - 15'd6;
    end
  end

  assign chan = req_i.addr[2 +: ChanW];

  // decode the word and work out the next state
  always_comb begin
    res         = '0;
    step_d      = step_q;
    count_d     = count_q;
    long_mode_d = long_mode_q;
    enables_d   = enables_q;
    count_tmp   = count_q;
    if (req_i.req_type == REQ_TICK) begin
      if (count_q == '0) begin
        res.quarter_frame = 1'b1;
        res.half_frame    = ~step_q[0];
        count_tmp         = step_len;
        step_d            = step_q + 2'd1;
      end
      count_d = (count_tmp != '0) ? count_tmp - 15'd1 : count_tmp;
    end else if (req_i.addr[15:4] == AddrChanBase[15:4]) begin
      if (req_i.addr[1:0] == RegLenLoad && enables_q[chan]) begin
        res.load_valid   = 1'b1;
        res.load_channel = chan;
        res.load_value   = LenLut[req_i.data[7:3]];
      end
    end else if (req_i.addr == AddrEnable) begin
      enables_d      = req_i.data[NUM_CHANNELS-1:0];
      res.clear_mask = ~req_i.data[NUM_CHANNELS-1:0];
    end else if (req_i.addr == AddrMode) begin
      long_mode_d = req_i.data[7];
      if (req_i.data[7]) begin
        step_d  = 2'd0;
        count_d = {{(CountW-1){1'b0}}, count_q[0]};
      end else begin
        step_d  = 2'd1;
        count_d = fl_ext + {{(CountW-1){1'b0}}, count_q[0]};
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      count_q     <= 15'd1;
      long_mode_q <= 1'b0;
      enables_q   <= '0;
    end else if (advance_i) begin
      step_q      <= step_d;
      count_q     <= count_d;
      long_mode_q <= long_mode_d;
      enables_q   <= enables_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

[rtl/apu_frame_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// apu_frame_sequencer_unit
// Frame sequencer with register decode: one request word in, one result
// word out, with an input register and an output register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   in_word_i   (req_word_t)
//  out       output     out_valid_o / out_ready_i out_word_o  (res_word_t)
//  cfg       input      cfg_we_i                  cfg_wdata_i (frame length)
//
//  one word per cycle sustained while the output takes results; a word's
//  result goes through the input register, then the output register.
//  the step countdown and decode sit between the two registers, and the
//  sequencer state updates as the word moves into the output register.
//  reset is asynchronous and active low; it sets the frame length to 7458.
//  an output stall holds the output register and a filled input register; input ready then drops.
`default_nettype none

module apu_frame_sequencer_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [apu_fs_pkg::FrameLenW-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire apu_fs_pkg::req_word_t            in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output apu_fs_pkg::res_word_t                 out_word_o
);
  import apu_fs_pkg::*;

  logic      in_valid_q;
  req_word_t in_word_q;
  logic      out_valid_q;
  res_word_t out_word_q;
  res_word_t res;
  logic      advance;
  logic      in_accept;

  // move the input word on when the output register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
  end

  // sequencer and decode
  apu_fs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .req_i       (in_word_q),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[rtl/apu_fs_checker.sv]
// ----------------------------------------------------------------------------
// apu_fs_checker
// Port-level checks on the frame sequencer's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_fs_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire apu_fs_pkg::res_word_t out_word_o
);
  import apu_fs_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // half-frame strobe only comes with a quarter-frame strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.half_frame |-> out_word_o.quarter_frame)
    else $error("half frame without quarter frame");

  // load fields are zero without a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.load_valid |->
      out_word_o.load_channel == '0 && out_word_o.load_value == '0)
    else $error("load fields set without a load");

  // a tick strobe never comes with write effects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.quarter_frame |->
      !out_word_o.load_valid && out_word_o.clear_mask == '0)
    else $error("strobe mixed with write result");

endmodule

bind apu_frame_sequencer_unit apu_fs_checker u_apu_fs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

[tb/sv/apu_frame_sequencer_unit_test.sv]
// ----------------------------------------------------------------------------
// apu_frame_sequencer_unit_test
// Self-checking bench for the frame sequencer. A short table of directed
// request words runs first, then randomized ticks and register writes across
// several frame lengths. Each result word is compared with the row's result
// if given, else with an in-bench model of the step countdown and register
// decode, with random idle gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_frame_sequencer_unit_test;

  import apu_fs_pkg::*;

  // run sizing
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandWords   = 1950;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseWords  = RandWords / NumPhases;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles = 8;

  // frame length after reset and the largest value of the register
  localparam logic [FrameLenW-1:0] ResetFrameLen = 14'd7458;
  localparam logic [FrameLenW-1:0] MaxFrameLen   = 14'd16383;

  // first address past the channel registers
  localparam logic [15:0] AddrChanEnd = AddrChanBase + 16'h10;

  // length counter values indexed by data bits 7..3
  localparam logic [7:0] LoadLenTable [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  // frame lengths per random phase; the slot of the random-length phase
  // is replaced by a random small length
  localparam logic [FrameLenW-1:0] FrameLenPlan [NumPhases] = '{
    14'd16, 14'd0, 14'd1, 14'd2, MaxFrameLen, 14'd3, ResetFrameLen, 14'd16
  };
  localparam int unsigned RandLenPhase = 5;

  // directed table: request word, whether the result is given, result
  typedef struct packed {
    req_word_t word;
    logic      known;
    res_word_t res;
  } dir_row_t;

  localparam res_word_t NoRes = '0;
  localparam int unsigned NumDirRows = 25;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // first tick after reset only counts down
    '{'{REQ_TICK,  16'h0000,             8'h00}, 1'b1, NoRes},
    // second tick fires step 0; address and data are ignored on a tick
    '{'{REQ_TICK,  16'hFFFF,             8'hFF}, 1'b1,
      '{1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 4'h0}},
    // load on a disabled channel
    '{'{REQ_WRITE, AddrChanBase + 16'h3, 8'hFF}, 1'b1, NoRes},
    // enable writes and their clear masks
    '{'{REQ_WRITE, AddrEnable,           8'h0F}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrEnable,           8'hF0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 4'hF}},
    '{'{REQ_WRITE, AddrEnable,           8'h05}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 4'hA}},
    // loads on enabled and disabled channels, table ends
    '{'{REQ_WRITE, AddrChanBase + 16'h3, 8'h00}, 1'b1,
      '{1'b0, 1'b0, 1'b1, 2'd0, 8'h0A, 4'h0}},
    '{'{REQ_WRITE, AddrChanBase + 16'h7, 8'h08}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrChanBase + 16'hB, 8'hFF}, 1'b1,
      '{1'b0, 1'b0, 1'b1, 2'd2, 8'h1E, 4'h0}},
    '{'{REQ_WRITE, AddrEnable,           8'hFF}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrChanBase + 16'hF, 8'h08}, 1'b1,
      '{1'b0, 1'b0, 1'b1, 2'd3, 8'hFE, 4'h0}},
    // channel registers that never load
    '{'{REQ_WRITE, AddrChanBase,         8'hFF}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrChanBase + 16'hE, 8'hFF}, 1'b1, NoRes},
    // long mode restart
    '{'{REQ_WRITE, AddrMode,             8'h80}, 1'b1, NoRes},
    // addresses outside the decoded set
    '{'{REQ_WRITE, 16'hFFFF,             8'hFF}, 1'b1, NoRes},
    '{'{REQ_WRITE, 16'h0000,             8'h00}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrChanEnd,          8'hFF}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrChanBase - 16'h1, 8'hFF}, 1'b1, NoRes},
    '{'{REQ_WRITE, AddrEnable + 16'h1,   8'hFF}, 1'b1, NoRes},
    // ticks after the restart
    '{'{REQ_TICK,  16'h0000,             8'h00}, 1'b0, NoRes},
    '{'{REQ_TICK,  16'h0000,             8'h00}, 1'b0, NoRes},
    // short mode restart, then mode byte all zero
    '{'{REQ_WRITE, AddrMode,             8'h7F}, 1'b1, NoRes},
    '{'{REQ_TICK,  16'hAAAA,             8'h55}, 1'b0, NoRes},
    '{'{REQ_WRITE, AddrMode,             8'h00}, 1'b1, NoRes},
    '{'{REQ_TICK,  16'h5555,             8'hAA}, 1'b0, NoRes}
  };

  // clock and reset
  logic clk_i;
  logic rst_ni = 1'b0;

  // block ports
  logic                 cfg_we_i    = 1'b0;
  logic [FrameLenW-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  req_word_t            in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  res_word_t            out_word_o;

  // sequencer state as the bench sees it
  logic [FrameLenW-1:0] frame_len  = ResetFrameLen;
  logic [1:0]           seq_step   = 2'd0;
  logic [CountW-1:0]    seq_count  = 15'd1;
  logic                 seq_long   = 1'b0;
  logic [3:0]           chan_en    = 4'h0;

  // result words still due, oldest first
  res_word_t frame_results_due [$];

  // tallies
  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned quarter_seen = 0;
  int unsigned half_seen    = 0;
  int unsigned loads_seen   = 0;
  int unsigned clears_seen  = 0;
  int unsigned cycle_count  = 0;
  int unsigned sender_calm  = 0;

  apu_frame_sequencer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // reload length of a fired step; negative lengths clamp to zero
  function automatic logic [CountW-1:0] step_reload(logic [1:0] step);
    int len;
    len = int'(frame_len);
    if (step == 2'd1) begin
      len -= 2;
    end else if (step == 2'd3 && seq_long) begin
      len += int'(frame_len) - 6;
    end
    if (len < 0) begin
      len = 0;
    end
    return len[CountW-1:0];
  endfunction

  // result of one request word, advancing the sequencer state
  function automatic res_word_t predict_frame_word(req_word_t w);
    res_word_t r;
    logic [1:0] ch;
    r = '0;
    ch = w.addr[3:2];
    if (w.req_type == REQ_TICK) begin
      if (seq_count == '0) begin
        r.quarter_frame = 1'b1;
        r.half_frame    = (seq_step == 2'd0) || (seq_step == 2'd2);
        seq_count       = step_reload(seq_step);
        seq_step        = seq_step + 2'd1;
      end
      if (seq_count != '0) begin
        seq_count = seq_count - 15'd1;
      end
    end else if (w.addr >= AddrChanBase && w.addr < AddrChanEnd) begin
      if (w.addr[1:0] == RegLenLoad && chan_en[ch]) begin
        r.load_valid   = 1'b1;
        r.load_channel = ch;
        r.load_value   = LoadLenTable[w.data[7:3]];
      end
    end else if (w.addr == AddrEnable) begin
      chan_en      = w.data[3:0];
      r.clear_mask = ~w.data[3:0];
    end else if (w.addr == AddrMode) begin
      seq_long  = w.data[7];
      seq_count = seq_count & 15'd1;
      seq_step  = 2'd0;
      if (!seq_long) begin
        seq_step  = 2'd1;
        seq_count = seq_count + frame_len;
      end
    end
    return r;
  endfunction

  // idle gap before a request: mostly none or short, a few long, calm runs
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (sender_calm != 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      sender_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // random request: mostly ticks and decoded writes, some stray addresses
  function automatic req_word_t draw_request(output bit stray);
    req_word_t w;
    int unsigned r;
    w.req_type = REQ_WRITE;
    w.addr     = 16'($urandom());
    w.data     = 8'($urandom());
    stray      = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      w.req_type = REQ_TICK;
    end else if (r < 80) begin
      w.addr = AddrChanBase + 16'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 7) begin
        w.addr[1:0] = RegLenLoad;
      end
    end else if (r < 87) begin
      w.addr = AddrEnable;
    end else if (r < 93) begin
      w.addr = AddrMode;
    end else begin
      stray = !((w.addr >= AddrChanBase && w.addr < AddrChanEnd) ||
                w.addr == AddrEnable || w.addr == AddrMode);
    end
    return w;
  endfunction

  // present one word, wait for it to be taken, log its expected result
  task automatic send_word(req_word_t w, logic known, res_word_t given);
    int unsigned gap;
    res_word_t want;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_frame_word(w);
    frame_results_due.push_back(known ? given : want);
    words_sent++;
  endtask

  // wait until every result is back
  task automatic wait_results_done();
    while (frame_results_due.size() != 0) @(posedge clk_i);
  endtask

  // one field of a result word
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // result side stalls: ready runs with stalls between, a few long ones
  initial begin : ready_driver
    int unsigned run;
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                         : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                         : $urandom_range(0, 3);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_due.size() == 0) begin
        $error("unexpected result word 0x%0h", out_word_o);
        mismatches++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("quarter_frame", 8'(want.quarter_frame), 8'(out_word_o.quarter_frame));
        check_field("half_frame",    8'(want.half_frame),    8'(out_word_o.half_frame));
        check_field("load_valid",    8'(want.load_valid),    8'(out_word_o.load_valid));
        check_field("load_channel",  8'(want.load_channel),  8'(out_word_o.load_channel));
        check_field("load_value",    want.load_value,        out_word_o.load_value);
        check_field("clear_mask",    8'(want.clear_mask),    8'(out_word_o.clear_mask));
        if (want.quarter_frame) quarter_seen++;
        if (want.half_frame) half_seen++;
        if (want.load_valid) loads_seen++;
        if (want.clear_mask != '0) clears_seen++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    req_word_t w;
    bit stray;
    int unsigned taken;
    logic [FrameLenW-1:0] len;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset frame length
    for (int i = 0; i < NumDirRows; i++) begin
      send_word(DirRows[i].word, DirRows[i].known, DirRows[i].res);
    end

    // random phases, each at its own frame length
    for (int p = 0; p < NumPhases; p++) begin
      in_valid_i <= 1'b0;
      wait_results_done();
      repeat (SettleCycles) @(posedge clk_i);
      len = (p == RandLenPhase) ? FrameLenW'($urandom_range(3, 60)) : FrameLenPlan[p];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= len;
      @(posedge clk_i);
      frame_len = len;
      cfg_we_i <= 1'b0;
      taken = 0;
      while (taken < PhaseWords) begin
        w = draw_request(stray);
        send_word(w, 1'b0, NoRes);
        if (!stray) taken++;
      end
    end

    // drain and report
    in_valid_i <= 1'b0;
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d request words over %0d frame lengths", words_sent, NumPhases + 1);
    $display("seen %0d quarter-frame, %0d half-frame, %0d loads, %0d clears",
             quarter_seen, half_seen, loads_seen, clears_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
